>>> src/h264fua_pkg.sv
// ----------------------------------------------------------------------------
// h264fua_pkg: shared types for the FU-A depacketizer
// Parse phases, error codes and the command word handed from front to back.
// ----------------------------------------------------------------------------
package h264fua_pkg;

  localparam logic [7:0] ForbiddenMask = 8'b1000_0000;
  localparam logic [7:0] TypeMask      = 8'b0001_1111;
  localparam logic [4:0] FuAType       = 5'd28;
  localparam logic [7:0] StartLastByte = 8'h01;
  localparam logic [2:0] StartLastIdx  = 3'd3;
  localparam logic [2:0] StartHdrIdx   = 3'd4;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_FUHDR   = 2'd1,
    PH_PASS    = 2'd2,
    PH_DISCARD = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FORBIDDEN = 2'd1,
    ERR_SHORT     = 2'd2
  } err_code_e;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_START = 2'd1,
    CMD_MARK  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
    err_code_e  err;
  } cmd_t;

endpackage

>>> src/h264fua_front.sv
// ----------------------------------------------------------------------------
// h264fua_front: input parser
// Tracks the parse phase of the current unit and turns each input word into
// at most one command for the output sequencer.
// ----------------------------------------------------------------------------
module h264fua_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                q_full_i,
  output logic                push_o,
  output h264fua_pkg::cmd_t   cmd_o
);
  import h264fua_pkg::*;

  phase_e     phase_q, phase_d;
  logic [2:0] held_q, held_d;
  logic       accept;
  logic       is_fua;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_fua     = (in_byte_i[4:0] == FuAType);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      held_q  <= 3'd0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    push_o   = 1'b0;
    cmd_o    = '{kind: CMD_BYTE, data: in_byte_i, last: in_last_i, err: ERR_NONE};
    if (accept) begin
      phase_d = in_last_i ? PH_FIRST : PH_PASS;
      case (phase_q)
        PH_FIRST: begin
          if ((in_byte_i & ForbiddenMask) != 8'd0) begin
            push_o  = 1'b1;
            cmd_o   = '{kind: CMD_MARK, data: 8'd0, last: 1'b1, err: ERR_FORBIDDEN};
            phase_d = in_last_i ? PH_FIRST : PH_DISCARD;
          end else if (is_fua) begin
            if (in_last_i) begin
              push_o  = 1'b1;
              cmd_o   = '{kind: CMD_MARK, data: 8'd0, last: 1'b1, err: ERR_SHORT};
              phase_d = PH_FIRST;
            end else begin
              // hold the indicator until the FU header shows up
              held_d  = in_byte_i[7:5];
              phase_d = PH_FUHDR;
            end
          end else begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_START;
          end
        end
        PH_FUHDR: begin
          if (in_byte_i[7]) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_START;
            cmd_o.data = {held_q, in_byte_i[4:0]};
          end else if (in_last_i) begin
            push_o = 1'b1;
            cmd_o  = '{kind: CMD_MARK, data: 8'd0, last: 1'b1, err: ERR_NONE};
          end
        end
        PH_PASS: begin
          push_o = 1'b1;
        end
        default: begin
          // drop the rest of a bad unit
          phase_d = in_last_i ? PH_FIRST : PH_DISCARD;
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("command pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FUHDR) |-> $past(accept) || $stable(held_q))
    else $error("held header bits changed while waiting for FU header");

endmodule

>>> src/h264fua_queue.sv
// ----------------------------------------------------------------------------
// h264fua_queue: command queue
// Small register FIFO that decouples the parser from the output sequencer.
// ----------------------------------------------------------------------------
module h264fua_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  h264fua_pkg::cmd_t wdata_i,
  input  logic              pop_i,
  output h264fua_pkg::cmd_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  import h264fua_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

>>> src/h264fua_back.sv
// ----------------------------------------------------------------------------
// h264fua_back: output sequencer
// Expands each command into output words: start code plus header, a plain
// byte, or an end marker, into a registered output stage.
// ----------------------------------------------------------------------------
module h264fua_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  h264fua_pkg::cmd_t cmd_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              end_of_unit_o,
  output logic [1:0]        error_code_o
);
  import h264fua_pkg::*;

  logic [2:0] cnt_q, cnt_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       bvalid_q, bvalid_d;
  logic       end_q, end_d;
  err_code_e  err_q, err_d;
  logic       load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    cnt_d    = cnt_q;
    valid_d  = valid_q;
    byte_d   = byte_q;
    bvalid_d = bvalid_q;
    end_d    = end_q;
    err_d    = err_q;
    pop_o    = 1'b0;
    if (load) begin
      valid_d = !q_empty_i;
      if (!q_empty_i) begin
        if (cmd_i.kind == CMD_START && cnt_q != StartHdrIdx) begin
          // start code 00 00 00 01
          byte_d   = (cnt_q == StartLastIdx) ? StartLastByte : 8'h00;
          bvalid_d = 1'b1;
          end_d    = 1'b0;
          err_d    = ERR_NONE;
          cnt_d    = cnt_q + 3'd1;
        end else begin
          pop_o = 1'b1;
          cnt_d = 3'd0;
          case (cmd_i.kind)
            CMD_MARK: begin
              byte_d   = 8'd0;
              bvalid_d = 1'b0;
              end_d    = 1'b1;
              err_d    = cmd_i.err;
            end
            default: begin
              byte_d   = cmd_i.data;
              bvalid_d = 1'b1;
              end_d    = cmd_i.last;
              err_d    = ERR_NONE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    bvalid_q <= bvalid_d;
    end_q    <= end_d;
    err_q    <= err_d;
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bvalid_q;
  assign end_of_unit_o = end_q;
  assign error_code_o  = err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 3'd0) |-> !q_empty_i && cmd_i.kind == CMD_START)
    else $error("start sequence lost its command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= StartHdrIdx)
    else $error("start code counter out of range");

endmodule

>>> src/h264_fua_depacketizer.sv
// A result word passes through the command queue and then the registered
//   output stage; a start code plus header is five output words.
// One output word per cycle while out_stall_i is low; a payload word gives one
//   word, a unit start five; the input runs ahead only until the queue fills.
// Reset: rst_ni clears parse phase, queue pointers and output valid at once.
// ----------------------------------------------------------------------------
// h264_fua_depacketizer: RTP H.264 payload to Annex B byte stream
// Parser front end, command queue and output sequencer back end.
// ----------------------------------------------------------------------------
module h264_fua_depacketizer #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_unit_o,
  output logic [1:0] error_code_o
);
  import h264fua_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  h264fua_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  h264fua_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  h264fua_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (head_cmd),
    .q_empty_i     (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .end_of_unit_o (end_of_unit_o),
    .error_code_o  (error_code_o)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: FU-A depacketizer stimulus and Annex B output checker
// Feeds RTP payload units a word at a time with random gaps and output stalls.
// A local parser model predicts the Annex B words, and each output word is
// compared in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import h264fua_pkg::*;

  localparam int HoldStart = 100;
  localparam int HoldLen   = 120;
  localparam int DrainWait = 20;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;
  } payload_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eou;
    err_code_e  err;
  } annexb_word_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i     = 8'h00;
  logic       in_last_i     = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       end_of_unit_o;
  logic [1:0] error_code_o;

  payload_word_t pending_words[$];
  annexb_word_t  annexb_expected[$];

  phase_e     parse_q    = PH_FIRST;
  logic [2:0] hdr_bits_q = 3'd0;

  int  mismatches  = 0;
  bit  tx_quiet    = 1'b0;
  bit  rx_quiet    = 1'b0;
  int  tx_idle     = 0;
  int  rx_wait     = 0;
  int  run_cycles  = 0;
  logic long_hold  = 1'b0;

  h264_fua_depacketizer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .end_of_unit_o (end_of_unit_o),
    .error_code_o  (error_code_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_word(input logic [7:0] data, input logic last);
    payload_word_t w;
    w.data = data;
    w.last = last;
    w.gap  = tx_quiet ? 0 : $urandom_range(0, 6);
    pending_words = {pending_words, w};
  endtask

  function automatic void queue_annexb(input logic [7:0] data, input logic valid,
                                       input logic eou, input err_code_e err);
    annexb_word_t r;
    r.data  = data;
    r.valid = valid;
    r.eou   = eou;
    r.err   = err;
    annexb_expected = {annexb_expected, r};
  endfunction

  function automatic void queue_start_code(input logic [7:0] hdr, input logic last);
    queue_annexb(8'h00, 1'b1, 1'b0, ERR_NONE);
    queue_annexb(8'h00, 1'b1, 1'b0, ERR_NONE);
    queue_annexb(8'h00, 1'b1, 1'b0, ERR_NONE);
    queue_annexb(StartLastByte, 1'b1, 1'b0, ERR_NONE);
    queue_annexb(hdr, 1'b1, last, ERR_NONE);
  endfunction

  // Advance the parser model by one accepted payload word.
  function automatic void parse_payload_word(input logic [7:0] b, input logic last);
    phase_e nxt;
    nxt = last ? PH_FIRST : PH_PASS;
    case (parse_q)
      PH_FIRST: begin
        if ((b & ForbiddenMask) != 8'h00) begin
          queue_annexb(8'h00, 1'b0, 1'b1, ERR_FORBIDDEN);
          nxt = last ? PH_FIRST : PH_DISCARD;
        end else if ((b & TypeMask) == {3'b000, FuAType}) begin
          if (last) begin
            queue_annexb(8'h00, 1'b0, 1'b1, ERR_SHORT);
          end else begin
            hdr_bits_q = b[7:5];
            nxt = PH_FUHDR;
          end
        end else begin
          queue_start_code(b, last);
        end
      end
      PH_FUHDR: begin
        if ((b & ForbiddenMask) != 8'h00) begin
          queue_start_code({hdr_bits_q, b[4:0]}, last);
        end else if (last) begin
          queue_annexb(8'h00, 1'b0, 1'b1, ERR_NONE);
        end
      end
      PH_PASS: begin
        queue_annexb(b, 1'b1, last, ERR_NONE);
      end
      default: begin
        nxt = last ? PH_FIRST : PH_DISCARD;
      end
    endcase
    parse_q = nxt;
  endfunction

  // Input driver: hold the word while stalled, otherwise wait its gap and offer the next.
  always @(posedge clk_i or negedge rst_ni) begin
    payload_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_idle = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        parse_payload_word(in_byte_i, in_last_i);
      end
      if (pending_words.size() != 0 && tx_idle >= pending_words[0].gap) begin
        w = pending_words.pop_front();
        in_valid_i <= 1'b1;
        in_byte_i  <= w.data;
        in_last_i  <= w.last;
        tx_idle = 0;
      end else begin
        in_valid_i <= 1'b0;
        tx_idle++;
      end
    end
  end

  // Long output hold-off so the block backs up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cycles <= 0;
      long_hold  <= 1'b0;
    end else begin
      run_cycles <= run_cycles + 1;
      long_hold  <= (run_cycles >= HoldStart) && (run_cycles < HoldStart + HoldLen);
    end
  end

  // Output monitor: check each accepted word against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    annexb_word_t got;
    annexb_word_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.data  = out_byte_o;
        got.valid = byte_valid_o;
        got.eou   = end_of_unit_o;
        got.err   = err_code_e'(error_code_o);
        if (annexb_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: byte=%02h valid=%b eou=%b err=%0d",
                     got.data, got.valid, got.eou, got.err);
        end else begin
          want = annexb_expected.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp byte=%02h valid=%b eou=%b err=%0d, ",
                        "got byte=%02h valid=%b eou=%b err=%0d"},
                       want.data, want.valid, want.eou, want.err,
                       got.data, got.valid, got.eou, got.err);
          end
        end
        if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 6);
      end
      if (long_hold) begin
        out_stall_i <= 1'b1;
      end else if (rx_wait != 0) begin
        out_stall_i <= 1'b1;
        rx_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int         made;
    int         len;
    int         kind;
    logic [7:0] lead;

    // Plain units at the byte extremes.
    send_word(8'h00, 1'b1);
    send_word(8'h7F, 1'b0);
    send_word(8'hFF, 1'b1);
    // Forbidden bit: alone, then with a tail to drop.
    send_word(8'h80, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h55, 1'b1);
    // FU-A indicator that is also the last word.
    send_word(8'h7C, 1'b1);
    // FU-A start fragment with payload.
    send_word(8'h7C, 1'b0);
    send_word(8'h85, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h00, 1'b1);
    // FU-A middle fragment: headers emit nothing.
    send_word(8'h5C, 1'b0);
    send_word(8'h05, 1'b0);
    send_word(8'h11, 1'b1);
    // Non-start FU header as the last word gives an empty marker.
    send_word(8'h1C, 1'b0);
    send_word(8'h45, 1'b1);
    // Start FU header as the last word.
    send_word(8'h3C, 1'b0);
    send_word(8'hFF, 1'b1);

    made = 0;
    while (made < 80) begin
      if ($urandom_range(0, 3) == 0) tx_quiet = !tx_quiet;
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          lead = 8'($urandom) & 8'h7F;
          if (lead[4:0] == FuAType) lead[0] = ~lead[0];
          len = $urandom_range(1, 8);
        end
        3, 4, 5, 6: begin
          lead = (8'($urandom) & 8'h60) | {3'b000, FuAType};
          len  = $urandom_range(2, 8);
        end
        7: begin
          lead = (8'($urandom) & 8'h60) | {3'b000, FuAType};
          len  = 1;
        end
        8: begin
          lead = 8'($urandom) | 8'h80;
          len  = $urandom_range(1, 4);
        end
        default: begin
          lead = 8'($urandom);
          len  = $urandom_range(1, 5);
        end
      endcase
      send_word(lead, len == 1);
      for (int i = 1; i < len; i++) send_word(8'($urandom), i == len - 1);
      made += len;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || annexb_expected.size() != 0);
    repeat (DrainWait) @(negedge clk_i);

    if (annexb_expected.size() != 0) begin
      mismatches++;
      $display("%0d predicted words never arrived", annexb_expected.size());
    end
    if (mismatches == 0) begin
      $display("[h264_fua_depacketizer] OK");
    end else begin
      $display("[h264_fua_depacketizer] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for output words");
    $display("[h264_fua_depacketizer] ERROR");
    $finish;
  end

endmodule
